@@ rtl/sdspi_pkg.sv @@
// Shared types, constants and the frame byte function of the SD card SPI init sequencer.
// Used by sdspi_step and sd_card_spi_init_sequencer_core; depends on nothing.
package sdspi_pkg;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_WAKE,
      PH_CMD0,
      PH_CMD1,
      PH_CMD16,
      PH_WAIT0,
      PH_WAIT1,
      PH_DONE
   } phase_type;

   localparam logic [1:0] KIND_START = 2'd0;
   localparam logic [1:0] KIND_XFER_DONE = 2'd1;
   localparam logic [1:0] KIND_DELAY_DONE = 2'd2;

   localparam logic [1:0] ST_BUSY = 2'd0;
   localparam logic [1:0] ST_READY = 2'd1;
   localparam logic [1:0] ST_NO_IDLE = 2'd2;
   localparam logic [1:0] ST_NO_READY = 2'd3;

   localparam logic [1:0] CSR_RETRY_LIMIT = 2'd0;
   localparam logic [1:0] CSR_WAKEUP_BYTES = 2'd1;
   localparam logic [1:0] CSR_RESPONSE_BYTES = 2'd2;
   localparam logic [1:0] CSR_BLOCK_LENGTH = 2'd3;

   localparam logic [3:0] RETRY_LIMIT_RESET = 4'd10;
   localparam logic [4:0] WAKEUP_BYTES_RESET = 5'd10;
   localparam logic [3:0] RESPONSE_BYTES_RESET = 4'd8;
   localparam logic [31:0] BLOCK_LENGTH_RESET = 32'h0000_0200;

   localparam logic [7:0] CMD0_CODE = 8'h40;
   localparam logic [7:0] CMD1_CODE = 8'h41;
   localparam logic [7:0] CMD16_CODE = 8'h50;
   localparam logic [7:0] CMD0_CRC = 8'h95;
   localparam logic [7:0] IDLE_BYTE = 8'hFF;
   localparam logic [7:0] R1_IDLE = 8'h01;
   localparam logic [7:0] R1_READY = 8'h00;
   localparam logic [4:0] FRAME_LEN = 5'd6;
   localparam logic [4:0] POS_CRC = 5'd5;

   typedef struct packed {
      logic [3:0] retry_limit;
      logic [4:0] wakeup_bytes;
      logic [3:0] response_bytes;
      logic [31:0] block_length;
   } cfg_type;

   typedef struct packed {
      logic [7:0] tx_byte;
      logic transfer;
      logic chip_select;
      logic wait_request;
      logic [1:0] status;
   } result_type;

   // Byte at a given position of the six-byte command frame of a command phase.
   function automatic logic [7:0] frame_byte(phase_type ph, logic [4:0] pos,
                                             logic [31:0] blen);
      logic [7:0] code;
      logic [7:0] crc;
      logic [31:0] arg;
      logic [7:0] res;
      code = CMD0_CODE;
      crc = CMD0_CRC;
      arg = 32'd0;
      if (ph == PH_CMD1) begin
         code = CMD1_CODE;
         crc = IDLE_BYTE;
      end else if (ph == PH_CMD16) begin
         code = CMD16_CODE;
         crc = IDLE_BYTE;
         arg = blen;
      end
      case (pos)
         5'd0: res = code;
         5'd1: res = arg[31:24];
         5'd2: res = arg[23:16];
         5'd3: res = arg[15:8];
         5'd4: res = arg[7:0];
         POS_CRC: res = crc;
         default: res = IDLE_BYTE;
      endcase
      return res;
   endfunction

endpackage

@@ rtl/sdspi_step.sv @@
// Sequencer state and the combinational decision for one item of the SD card SPI init sequencer.
// Depends on sdspi_pkg; instantiated by sd_card_spi_init_sequencer_core.
module sdspi_step (
   input  logic clock,
   input  logic reset,
   input  logic fire,
   input  logic [1:0] kind,
   input  logic [7:0] rx_byte,
   input  sdspi_pkg::cfg_type cfg,
   output sdspi_pkg::result_type result
);
   import sdspi_pkg::*;

   typedef enum logic [2:0] {
      ACT_IGNORE,
      ACT_START_WAKE,
      ACT_WAKE_BYTE,
      ACT_BEGIN,
      ACT_FRAME_BYTE,
      ACT_RETRY,
      ACT_FINISH
   } act_type;

   phase_type phase_ff, phase_in;
   logic [4:0] pos_ff, pos_in;
   logic [3:0] attempt_ff, attempt_in;
   logic [7:0] last_rsp_ff, last_rsp_in;
   logic [1:0] final_status_ff, final_status_in;

   act_type act;
   phase_type target;
   logic [1:0] fin_status;
   logic in_cmd;
   logic [7:0] rsp_upd;
   logic [4:0] pos_inc;
   logic more_bytes;
   logic rsp_ok;
   logic [3:0] attempt_inc;
   logic [3:0] limit;
   logic exhausted;
   logic [1:0] cur_status;

   assign in_cmd = (phase_ff inside {PH_CMD0, PH_CMD1, PH_CMD16});
   assign rsp_upd = (in_cmd && pos_ff >= FRAME_LEN && rx_byte != IDLE_BYTE) ?
                    rx_byte : last_rsp_ff;
   assign pos_inc = pos_ff + 5'd1;
   assign more_bytes = {1'b0, pos_inc} < ({1'b0, FRAME_LEN} + {2'b00, cfg.response_bytes});
   assign rsp_ok = (phase_ff == PH_CMD0) ? (rsp_upd == R1_IDLE) : (rsp_upd == R1_READY);
   assign attempt_inc = attempt_ff + 4'd1;
   assign limit = (cfg.retry_limit == 4'd0) ? 4'd1 : cfg.retry_limit;
   assign exhausted = attempt_inc >= limit;
   assign cur_status = (phase_ff == PH_DONE) ? final_status_ff : ST_BUSY;

   always_comb begin
      act = ACT_IGNORE;
      target = PH_CMD0;
      fin_status = ST_READY;
      case (kind)
         KIND_START: begin
            if (cfg.wakeup_bytes == 5'd0) begin
               act = ACT_BEGIN;
               target = PH_CMD0;
            end else begin
               act = ACT_START_WAKE;
            end
         end
         KIND_XFER_DONE: begin
            if (phase_ff == PH_WAKE) begin
               if (pos_ff < cfg.wakeup_bytes) begin
                  act = ACT_WAKE_BYTE;
               end else begin
                  act = ACT_BEGIN;
                  target = PH_CMD0;
               end
            end else if (in_cmd) begin
               if (more_bytes) begin
                  act = ACT_FRAME_BYTE;
               end else if (phase_ff == PH_CMD16) begin
                  act = ACT_FINISH;
                  fin_status = ST_READY;
               end else if (rsp_ok) begin
                  act = ACT_BEGIN;
                  target = (phase_ff == PH_CMD0) ? PH_CMD1 : PH_CMD16;
               end else if (exhausted) begin
                  act = ACT_FINISH;
                  fin_status = (phase_ff == PH_CMD0) ? ST_NO_IDLE : ST_NO_READY;
               end else begin
                  act = ACT_RETRY;
                  target = (phase_ff == PH_CMD0) ? PH_WAIT0 : PH_WAIT1;
               end
            end
         end
         KIND_DELAY_DONE: begin
            if (phase_ff == PH_WAIT0) begin
               act = ACT_BEGIN;
               target = PH_CMD0;
            end else if (phase_ff == PH_WAIT1) begin
               act = ACT_BEGIN;
               target = PH_CMD1;
            end
         end
         default: act = ACT_IGNORE;
      endcase
   end

   // Next state.
   always_comb begin
      phase_in = phase_ff;
      pos_in = pos_ff;
      attempt_in = attempt_ff;
      last_rsp_in = last_rsp_ff;
      final_status_in = final_status_ff;
      if (fire) begin
         if (kind == KIND_START) begin
            attempt_in = 4'd0;
            final_status_in = ST_BUSY;
            last_rsp_in = IDLE_BYTE;
         end
         case (act)
            ACT_START_WAKE: begin
               phase_in = PH_WAKE;
               pos_in = 5'd1;
            end
            ACT_WAKE_BYTE: pos_in = pos_inc;
            ACT_BEGIN: begin
               phase_in = target;
               pos_in = 5'd0;
               last_rsp_in = IDLE_BYTE;
               if (in_cmd && kind == KIND_XFER_DONE) begin
                  attempt_in = 4'd0;
               end
            end
            ACT_FRAME_BYTE: begin
               pos_in = pos_inc;
               last_rsp_in = rsp_upd;
            end
            ACT_RETRY: begin
               phase_in = target;
               pos_in = pos_inc;
               last_rsp_in = rsp_upd;
               attempt_in = attempt_inc;
            end
            ACT_FINISH: begin
               phase_in = PH_DONE;
               pos_in = pos_inc;
               last_rsp_in = rsp_upd;
               final_status_in = fin_status;
               if (phase_ff != PH_CMD16) begin
                  attempt_in = attempt_inc;
               end
            end
            default: phase_in = phase_ff;
         endcase
      end
   end

   // Result of the item.
   always_comb begin
      result.tx_byte = IDLE_BYTE;
      result.transfer = 1'b0;
      result.chip_select = 1'b0;
      result.wait_request = 1'b0;
      result.status = cur_status;
      case (act)
         ACT_START_WAKE, ACT_WAKE_BYTE: begin
            result.transfer = 1'b1;
            result.status = ST_BUSY;
         end
         ACT_BEGIN: begin
            result.tx_byte = frame_byte(target, 5'd0, cfg.block_length);
            result.transfer = 1'b1;
            result.chip_select = 1'b1;
            result.status = ST_BUSY;
         end
         ACT_FRAME_BYTE: begin
            result.tx_byte = frame_byte(phase_ff, pos_inc, cfg.block_length);
            result.transfer = 1'b1;
            result.chip_select = 1'b1;
            result.status = ST_BUSY;
         end
         ACT_RETRY: begin
            result.wait_request = 1'b1;
            result.status = ST_BUSY;
         end
         ACT_FINISH: result.status = fin_status;
         default: result.status = cur_status;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         pos_ff <= 5'd0;
         attempt_ff <= 4'd0;
         last_rsp_ff <= IDLE_BYTE;
         final_status_ff <= ST_BUSY;
      end else begin
         phase_ff <= phase_in;
         pos_ff <= pos_in;
         attempt_ff <= attempt_in;
         last_rsp_ff <= last_rsp_in;
         final_status_ff <= final_status_in;
      end
   end

   a_done_has_status: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_DONE |-> final_status_ff != ST_BUSY)
      else $error("finished sequence carries a busy status");

   a_wait_after_try: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_WAIT0 || phase_ff == PH_WAIT1) |-> attempt_ff != 4'd0)
      else $error("retry delay pending without a counted try");

   a_pos_in_frame: assert property (@(posedge clock) disable iff (reset)
      in_cmd |-> pos_ff <= 5'd21)
      else $error("byte position ran past the longest command exchange");

   a_select_only_on_transfer: assert property (@(posedge clock) disable iff (reset)
      fire |-> (result.transfer || !result.chip_select))
      else $error("chip select asserted without a byte transfer");

endmodule

@@ rtl/sd_card_spi_init_sequencer_core.sv @@
// Top level of the SD card SPI-mode init sequencer: handshakes, configuration registers
// and the result register. Depends on sdspi_pkg and sdspi_step.
//
// Usage: each req_ transfer is one event: start, finished SPI byte exchange (with the
// received byte) or elapsed retry delay. Every accepted event yields exactly one rsp_
// transfer telling the link which byte to exchange next, whether chip select is asserted,
// whether a retry delay is wanted, and the sequence status.
// The event is captured in an input register and decided combinationally against the
// sequencer state; the decision is stored in the result register, which drives rsp_valid
// and the result payload. One event per cycle is sustained while the receiver does not
// stall; the combinational next-state decision sets that rate.
// When the receiver stalls, the result register holds its payload and the input register
// keeps one further event; req_stall then rises until the result is taken.
// The user writes registers via csr_write, csr_index and csr_wdata only while idle; the block
// does not enforce this. Synchronous reset loads the register defaults (10 tries, 10 wake-up
// bytes, 8 response reads, block length 512), returns the sequencer to idle and empties both stages.
module sd_card_spi_init_sequencer_core (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic [1:0] req_kind,
   input  logic [7:0] req_rx_byte,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic [7:0] rsp_tx_byte,
   output logic rsp_transfer,
   output logic rsp_chip_select,
   output logic rsp_wait_request,
   output logic [1:0] rsp_status,
   input  logic csr_write,
   input  logic [1:0] csr_index,
   input  logic [31:0] csr_wdata
);
   import sdspi_pkg::*;

   cfg_type cfg_ff, cfg_in;
   logic stg_valid_ff, stg_valid_in;
   logic [1:0] stg_kind_ff;
   logic [7:0] stg_rx_ff;
   logic rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff;
   result_type step_result;
   logic req_accept;
   logic advance;

   assign advance = stg_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = stg_valid_ff && !advance;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      stg_valid_in = stg_valid_ff;
      if (req_accept) begin
         stg_valid_in = 1'b1;
      end else if (advance) begin
         stg_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_RETRY_LIMIT: cfg_in.retry_limit = csr_wdata[3:0];
            CSR_WAKEUP_BYTES: cfg_in.wakeup_bytes = csr_wdata[4:0];
            CSR_RESPONSE_BYTES: cfg_in.response_bytes = csr_wdata[3:0];
            CSR_BLOCK_LENGTH: cfg_in.block_length = csr_wdata;
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   sdspi_step u_step (
      .clock(clock),
      .reset(reset),
      .fire(advance),
      .kind(stg_kind_ff),
      .rx_byte(stg_rx_ff),
      .cfg(cfg_ff),
      .result(step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cfg_ff.retry_limit <= RETRY_LIMIT_RESET;
         cfg_ff.wakeup_bytes <= WAKEUP_BYTES_RESET;
         cfg_ff.response_bytes <= RESPONSE_BYTES_RESET;
         cfg_ff.block_length <= BLOCK_LENGTH_RESET;
      end else begin
         stg_valid_ff <= stg_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         cfg_ff <= cfg_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         stg_kind_ff <= req_kind;
         stg_rx_ff <= req_rx_byte;
      end
      if (advance) begin
         rsp_ff <= step_result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_tx_byte = rsp_ff.tx_byte;
   assign rsp_transfer = rsp_ff.transfer;
   assign rsp_chip_select = rsp_ff.chip_select;
   assign rsp_wait_request = rsp_ff.wait_request;
   assign rsp_status = rsp_ff.status;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |-> !advance)
      else $error("result register overwritten while the receiver stalls");

   a_stage_keeps_item: assert property (@(posedge clock) disable iff (reset)
      stg_valid_ff && !advance |=> stg_valid_ff)
      else $error("held request lost before it was decided");

   a_result_follows_item: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("decided item produced no result");

endmodule

@@ sim/sdspi_init_tb_pkg.sv @@
`timescale 1ns / 100ps
// Scoreboard class for the SD card SPI init sequencer testbench: predicts the result of
// every request transfer and checks each response transfer against the oldest prediction.
// Depends on sdspi_pkg for the phase, status, kind and register codes.
package sdspi_init_tb_pkg;
   import sdspi_pkg::*;

   localparam logic [1:0] KIND_UNUSED = 2'd3;
   localparam int REPORT_LIMIT = 10;

   class sdspi_init_scoreboard;
      cfg_type cfg;
      phase_type phase;
      logic [4:0] byte_pos;
      logic [3:0] attempts;
      logic [7:0] last_resp;
      logic [1:0] final_st;
      result_type awaited_results[$];
      int mismatches;

      function void clear();
         cfg.retry_limit = RETRY_LIMIT_RESET;
         cfg.wakeup_bytes = WAKEUP_BYTES_RESET;
         cfg.response_bytes = RESPONSE_BYTES_RESET;
         cfg.block_length = BLOCK_LENGTH_RESET;
         phase = PH_IDLE;
         byte_pos = 5'd0;
         attempts = 4'd0;
         last_resp = IDLE_BYTE;
         final_st = ST_BUSY;
         awaited_results.delete();
         mismatches = 0;
      endfunction

      function void set_register(logic [1:0] idx, logic [31:0] data);
         case (idx)
            CSR_RETRY_LIMIT: cfg.retry_limit = data[3:0];
            CSR_WAKEUP_BYTES: cfg.wakeup_bytes = data[4:0];
            CSR_RESPONSE_BYTES: cfg.response_bytes = data[3:0];
            CSR_BLOCK_LENGTH: cfg.block_length = data;
            default: ;
         endcase
      endfunction

      function int pending();
         return awaited_results.size();
      endfunction

      function result_type shape_result(logic [7:0] tx, logic xfer, logic cs, logic wreq,
                                        logic [1:0] st);
         result_type r;
         r.tx_byte = tx;
         r.transfer = xfer;
         r.chip_select = cs;
         r.wait_request = wreq;
         r.status = st;
         return r;
      endfunction

      // The six frame bytes of the current command; reads after the frame clock out 0xFF.
      function logic [7:0] command_byte();
         logic [47:0] frame;
         case (phase)
            PH_CMD1: frame = {CMD1_CODE, 32'd0, IDLE_BYTE};
            PH_CMD16: frame = {CMD16_CODE, cfg.block_length, IDLE_BYTE};
            default: frame = {CMD0_CODE, 32'd0, CMD0_CRC};
         endcase
         if (byte_pos >= FRAME_LEN) return IDLE_BYTE;
         return 8'(frame >> (40 - 8 * int'(byte_pos)));
      endfunction

      function result_type open_command(phase_type ph);
         phase = ph;
         byte_pos = 5'd0;
         last_resp = IDLE_BYTE;
         return shape_result(command_byte(), 1'b1, 1'b1, 1'b0, ST_BUSY);
      endfunction

      function result_type conclude(logic [1:0] st);
         phase = PH_DONE;
         final_st = st;
         return shape_result(IDLE_BYTE, 1'b0, 1'b0, 1'b0, st);
      endfunction

      function result_type retry_or_fail(phase_type wait_ph, logic [1:0] err);
         logic [3:0] limit;
         limit = (cfg.retry_limit == 4'd0) ? 4'd1 : cfg.retry_limit;
         attempts = attempts + 4'd1;
         if (attempts >= limit) return conclude(err);
         phase = wait_ph;
         return shape_result(IDLE_BYTE, 1'b0, 1'b0, 1'b1, ST_BUSY);
      endfunction

      function result_type judge_response();
         if (phase == PH_CMD0) begin
            if (last_resp == R1_IDLE) begin
               attempts = 4'd0;
               return open_command(PH_CMD1);
            end
            return retry_or_fail(PH_WAIT0, ST_NO_IDLE);
         end
         if (phase == PH_CMD1) begin
            if (last_resp == R1_READY) begin
               attempts = 4'd0;
               return open_command(PH_CMD16);
            end
            return retry_or_fail(PH_WAIT1, ST_NO_READY);
         end
         return conclude(ST_READY);
      endfunction

      // Returns 1 when the transfer moved the sequencer, 0 when it was ignored.
      function bit note_request(logic [1:0] kind, logic [7:0] rx);
         result_type r;
         bit acted;
         acted = 1'b1;
         r = shape_result(IDLE_BYTE, 1'b0, 1'b0, 1'b0,
                          (phase == PH_DONE) ? final_st : ST_BUSY);
         case (kind)
            KIND_START: begin
               attempts = 4'd0;
               final_st = ST_BUSY;
               last_resp = IDLE_BYTE;
               if (cfg.wakeup_bytes == 5'd0) begin
                  r = open_command(PH_CMD0);
               end else begin
                  phase = PH_WAKE;
                  byte_pos = 5'd1;
                  r = shape_result(IDLE_BYTE, 1'b1, 1'b0, 1'b0, ST_BUSY);
               end
            end
            KIND_XFER_DONE: begin
               if (phase == PH_WAKE) begin
                  if (byte_pos < cfg.wakeup_bytes) begin
                     byte_pos = byte_pos + 5'd1;
                     r = shape_result(IDLE_BYTE, 1'b1, 1'b0, 1'b0, ST_BUSY);
                  end else begin
                     r = open_command(PH_CMD0);
                  end
               end else if (phase == PH_CMD0 || phase == PH_CMD1 || phase == PH_CMD16) begin
                  if (byte_pos >= FRAME_LEN && rx != IDLE_BYTE) last_resp = rx;
                  byte_pos = byte_pos + 5'd1;
                  if (int'(byte_pos) < int'(FRAME_LEN) + int'(cfg.response_bytes))
                     r = shape_result(command_byte(), 1'b1, 1'b1, 1'b0, ST_BUSY);
                  else
                     r = judge_response();
               end else begin
                  acted = 1'b0;
               end
            end
            KIND_DELAY_DONE: begin
               if (phase == PH_WAIT0) r = open_command(PH_CMD0);
               else if (phase == PH_WAIT1) r = open_command(PH_CMD1);
               else acted = 1'b0;
            end
            default: acted = 1'b0;
         endcase
         awaited_results.push_back(r);
         return acted;
      endfunction

      function void compare_field(string field, logic [7:0] want, logic [7:0] got);
         if (got !== want) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("mismatch on %s: expected %0h, actual %0h", field, want, got);
         end
      endfunction

      function void check_result(result_type got);
         result_type want;
         if (awaited_results.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("result with no request pending: tx_byte %0h, status %0d",
                        got.tx_byte, got.status);
            return;
         end
         want = awaited_results.pop_front();
         compare_field("tx_byte", want.tx_byte, got.tx_byte);
         compare_field("transfer", 8'(want.transfer), 8'(got.transfer));
         compare_field("chip_select", 8'(want.chip_select), 8'(got.chip_select));
         compare_field("wait_request", 8'(want.wait_request), 8'(got.wait_request));
         compare_field("status", 8'(want.status), 8'(got.status));
      endfunction
   endclass

endpackage

@@ sim/tb_sd_card_spi_init_sequencer_core.sv @@
`timescale 1ns / 100ps
// Testbench top for sd_card_spi_init_sequencer_core: plays the SD card side with directed
// and random byte exchanges under several register settings and random idling.
// Depends on sdspi_pkg, sdspi_init_tb_pkg and the RTL of the block.
module tb_sd_card_spi_init_sequencer_core;
   import sdspi_pkg::*;
   import sdspi_init_tb_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [1:0] req_kind = KIND_START;
   logic [7:0] req_rx_byte = IDLE_BYTE;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [7:0] rsp_tx_byte;
   logic rsp_transfer;
   logic rsp_chip_select;
   logic rsp_wait_request;
   logic [1:0] rsp_status;
   logic csr_write = 1'b0;
   logic [1:0] csr_index = CSR_RETRY_LIMIT;
   logic [31:0] csr_wdata = 32'd0;

   sdspi_init_scoreboard sb;
   bit sender_gaps = 1'b1;
   bit receiver_gaps = 1'b1;
   int active_items = 0;
   int idle_cycles;

   sd_card_spi_init_sequencer_core dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_kind(req_kind),
      .req_rx_byte(req_rx_byte),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_tx_byte(rsp_tx_byte),
      .rsp_transfer(rsp_transfer),
      .rsp_chip_select(rsp_chip_select),
      .rsp_wait_request(rsp_wait_request),
      .rsp_status(rsp_status),
      .csr_write(csr_write),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   always @(negedge clock) begin
      rsp_stall <= receiver_gaps && ($urandom_range(99) < 20);
   end

   always @(posedge clock) begin
      result_type got;
      got.tx_byte = rsp_tx_byte;
      got.transfer = rsp_transfer;
      got.chip_select = rsp_chip_select;
      got.wait_request = rsp_wait_request;
      got.status = rsp_status;
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) sb.check_result(got);
   end

   initial begin
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_stall === 1'b0) || (rsp_valid === 1'b1 && !rsp_stall))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("*** FAILED ***");
      $finish;
   end

   // Entered and left at a falling edge; valid stays high so the next call can replace
   // the payload without a gap.
   task automatic send_item(logic [1:0] kind, logic [7:0] rx);
      while (sender_gaps && $urandom_range(99) < 20) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_rx_byte <= rx;
      do @(posedge clock); while (req_stall);
      if (sb.note_request(kind, rx)) active_items++;
      @(negedge clock);
   endtask

   task automatic hold_until_drained();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
   endtask

   task automatic load_config(logic [3:0] retries, logic [4:0] wake, logic [3:0] reads,
                              logic [31:0] blen);
      logic [1:0] idx [4];
      logic [31:0] val [4];
      idx = '{CSR_RETRY_LIMIT, CSR_WAKEUP_BYTES, CSR_RESPONSE_BYTES, CSR_BLOCK_LENGTH};
      val = '{32'(retries), 32'(wake), 32'(reads), blen};
      hold_until_drained();
      csr_write <= 1'b1;
      for (int i = 0; i < 4; i++) begin
         csr_index <= idx[i];
         csr_wdata <= val[i];
         @(negedge clock);
         sb.set_register(idx[i], val[i]);
      end
      csr_write <= 1'b0;
   endtask

   // Mostly the transfer the sequencer asked for, answered like a card would; now and
   // then a stray or restarting transfer.
   function automatic void pick_item(output logic [1:0] kind, output logic [7:0] rx);
      int roll;
      rx = 8'($urandom);
      roll = $urandom_range(999);
      if (roll < 4) begin
         kind = KIND_START;
         return;
      end
      if (roll < 50) begin
         kind = 2'($urandom_range(KIND_XFER_DONE, KIND_UNUSED));
         return;
      end
      case (sb.phase)
         PH_WAKE: kind = KIND_XFER_DONE;
         PH_CMD0, PH_CMD1, PH_CMD16: begin
            kind = KIND_XFER_DONE;
            if (sb.byte_pos >= FRAME_LEN) begin
               roll = $urandom_range(99);
               if (roll < 60) rx = IDLE_BYTE;
               else if (roll < 80) rx = (sb.phase == PH_CMD1) ? R1_READY : R1_IDLE;
            end
         end
         PH_WAIT0, PH_WAIT1: kind = KIND_DELAY_DONE;
         default: kind = KIND_START;
      endcase
   endfunction

   task automatic run_random(int count);
      logic [1:0] kind;
      logic [7:0] rx;
      int goal;
      goal = active_items + count;
      while (active_items < goal) begin
         pick_item(kind, rx);
         send_item(kind, rx);
      end
   endtask

   task automatic run_phase(logic [3:0] retries, logic [4:0] wake, logic [3:0] reads,
                            logic [31:0] blen);
      load_config(retries, wake, reads, blen);
      run_random(140);
      hold_until_drained();
      run_random(140);
   endtask

   initial begin
      sb = new;
      sb.clear();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Stray transfers while idle and while waking up, then a restart.
      send_item(KIND_UNUSED, 8'($urandom));
      send_item(KIND_XFER_DONE, 8'($urandom));
      send_item(KIND_DELAY_DONE, 8'($urandom));
      send_item(KIND_START, 8'($urandom));
      send_item(KIND_DELAY_DONE, 8'($urandom));
      send_item(KIND_START, 8'($urandom));

      // Retry limit zero, no wake-up bytes and no reads: one try of CMD0 that fails.
      load_config(4'd0, 5'd0, 4'd0, 32'hFFFF_FFFF);
      send_item(KIND_START, 8'h00);
      repeat (6) send_item(KIND_XFER_DONE, 8'($urandom));
      send_item(KIND_XFER_DONE, 8'h00);

      // CMD0 answered as idle on its single read.
      load_config(4'd1, 5'd1, 4'd1, 32'd0);
      send_item(KIND_START, 8'($urandom));
      send_item(KIND_XFER_DONE, 8'($urandom));
      repeat (6) send_item(KIND_XFER_DONE, 8'($urandom));
      send_item(KIND_XFER_DONE, R1_IDLE);

      sender_gaps = 1'b0;
      receiver_gaps = 1'b0;
      run_phase(RETRY_LIMIT_RESET, WAKEUP_BYTES_RESET, RESPONSE_BYTES_RESET,
                BLOCK_LENGTH_RESET);
      sender_gaps = 1'b1;
      receiver_gaps = 1'b1;
      run_phase(4'd15, 5'd31, 4'd15, $urandom);
      run_phase(4'd1, 5'd0, 4'd1, 32'd0);
      run_phase(4'd0, 5'd3, 4'd8, 32'hFFFF_FFFF);
      run_phase(4'($urandom_range(1, 15)), 5'($urandom), 4'($urandom_range(1, 8)), $urandom);
      run_phase(4'd3, 5'd1, 4'd2, $urandom);

      hold_until_drained();
      repeat (8) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/sdspi_pkg.sv
rtl/sdspi_step.sv
rtl/sd_card_spi_init_sequencer_core.sv
sim/sdspi_init_tb_pkg.sv
sim/tb_sd_card_spi_init_sequencer_core.sv
